### hw/rtl/imsu_pkg.sv
package imsu_pkg;

  // Fixed field widths
  localparam int SITE_W     = 16;
  localparam int RND_W      = 16;
  localparam int MAG_W      = 18;
  localparam int ENE_W      = 19;
  localparam int CFG_SIDE_W = 9;
  localparam int THR_W      = 16;

  // Configuration port
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  localparam logic [PADDR_W-3:0] REG_SIDE  = 2'd0;
  localparam logic [PADDR_W-3:0] REG_SMALL = 2'd1;
  localparam logic [PADDR_W-3:0] REG_LARGE = 2'd2;

  // Lattice limits and register resets
  localparam int MAX_SIDE_DEF = 256;
  localparam int MIN_SIDE     = 2;
  localparam int RESET_SIDE   = 256;
  localparam int RESET_SMALL  = 8869;
  localparam int RESET_LARGE  = 1200;

  typedef enum logic [2:0] {
    ADDR_SITE,
    ADDR_RIGHT,
    ADDR_LEFT,
    ADDR_DOWN,
    ADDR_UP,
    ADDR_CLEAR
  } addr_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      cap_spin;
    logic      acc;
    logic      finish;
    logic      clr_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic err;
    logic clr_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

### hw/rtl/imsu_regs.sv
module imsu_regs import imsu_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [PADDR_W-1:0]                           paddr,
  input  logic [DATA_W-1:0]                            pwdata,
  output logic [DATA_W-1:0]                            prdata,
  output logic                                         pready,
  output logic [$clog2(MAX_SIDE+1)-1:0]                side_use,
  output logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0]       n,
  output logic [THR_W-1:0]                             thr_small,
  output logic [THR_W-1:0]                             thr_large,
  output logic                                         init
);

  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int COUNT_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int CL_W      = (SIDE_W > CFG_SIDE_W) ? SIDE_W : CFG_SIDE_W;
  localparam int RESET_USE = (RESET_SIDE > MAX_SIDE) ? MAX_SIDE :
                             ((RESET_SIDE < MIN_SIDE) ? MIN_SIDE : RESET_SIDE);

  logic [CFG_SIDE_W-1:0] side_raw;
  logic [PADDR_W-3:0]    idx;
  logic                  wr;
  logic [CL_W-1:0]       side_wr;
  logic [SIDE_W-1:0]     side_clamp;
  logic [2*SIDE_W-1:0]   side_sq;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel & penable & pwrite & pready;

  always_comb begin
    side_wr = CL_W'(pwdata[CFG_SIDE_W-1:0]);
    if (side_wr < CL_W'(MIN_SIDE)) begin
      side_clamp = SIDE_W'(MIN_SIDE);
    end else if (side_wr > CL_W'(MAX_SIDE)) begin
      side_clamp = SIDE_W'(MAX_SIDE);
    end else begin
      side_clamp = SIDE_W'(side_wr);
    end
    side_sq = side_clamp * side_clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_raw  <= CFG_SIDE_W'(RESET_SIDE);
      side_use  <= SIDE_W'(RESET_USE);
      n         <= COUNT_W'(RESET_USE * RESET_USE);
      thr_small <= THR_W'(RESET_SMALL);
      thr_large <= THR_W'(RESET_LARGE);
      init      <= 1'b1;
    end else begin
      init <= 1'b0;
      if (wr) begin
        case (idx)
          REG_SIDE: begin
            side_raw <= pwdata[CFG_SIDE_W-1:0];
            side_use <= side_clamp;
            n        <= COUNT_W'(side_sq);
            init     <= 1'b1;
          end
          REG_SMALL: thr_small <= pwdata[THR_W-1:0];
          REG_LARGE: thr_large <= pwdata[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_SIDE:  prdata = DATA_W'(side_raw);
      REG_SMALL: prdata = DATA_W'(thr_small);
      REG_LARGE: prdata = DATA_W'(thr_large);
      default:   prdata = '0;
    endcase
  end

endmodule

### hw/rtl/imsu_ctrl.sv
module imsu_ctrl import imsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      init,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SITE,
    S_RIGHT,
    S_LEFT,
    S_DOWN,
    S_UP,
    S_DEC
  } state_t;

  state_t state, state_next;
  logic   busy;

  // a pending re-init blocks the input before the state machine reacts to it
  assign in_stall = busy | init;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.addr_sel = ADDR_SITE;
    case (state)
      S_CLEAR: begin
        cmd.clr_en   = 1'b1;
        cmd.addr_sel = ADDR_CLEAR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_in = 1'b1;
          state_next  = S_SITE;
        end
      end
      S_SITE: begin
        if (sts.err) begin
          state_next = S_DEC;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_RIGHT;
        end
      end
      S_RIGHT: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_RIGHT;
        cmd.cap_spin = 1'b1;
        state_next   = S_LEFT;
      end
      S_LEFT: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_LEFT;
        cmd.acc      = 1'b1;
        state_next   = S_DOWN;
      end
      S_DOWN: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_DOWN;
        cmd.acc      = 1'b1;
        state_next   = S_UP;
      end
      S_UP: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_UP;
        cmd.acc      = 1'b1;
        state_next   = S_DEC;
      end
      S_DEC: begin
        // hold here while the previous result is still stalled
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase

    // lattice re-init restarts the clear sweep
    if (init) begin
      state_next  = S_CLEAR;
      cmd.clr_en  = 1'b0;
      cmd.load_in = 1'b0;
      cmd.finish  = 1'b0;
    end
  end

endmodule

### hw/rtl/imsu_dp.sv
module imsu_dp import imsu_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ctrl_cmd_t                              cmd,
  output ctrl_sts_t                              sts,
  input  logic                                   init,
  input  logic [$clog2(MAX_SIDE+1)-1:0]          side_use,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0] n,
  input  logic [THR_W-1:0]                       thr_small,
  input  logic [THR_W-1:0]                       thr_large,
  input  logic [SITE_W-1:0]                      site_index,
  input  logic [RND_W-1:0]                       random_fraction,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic                                   flipped,
  output logic                                   spin_after,
  output logic signed [MAG_W-1:0]                magnetisation,
  output logic signed [ENE_W-1:0]                energy,
  output logic                                   index_error
);

  localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W   = ((COUNT_W > SITE_W) ? COUNT_W : SITE_W) + 1;

  logic                     mem [DEPTH];
  logic                     rd_q;
  logic [SITE_W-1:0]        site;
  logic [RND_W-1:0]         rnd;
  logic                     err;
  logic                     spin_s;
  logic [2:0]               ups;
  logic [ADDR_W-1:0]        clr_addr;
  logic signed [MAG_W-1:0]  mag;
  logic signed [ENE_W-1:0]  ene;

  logic [CMP_W-1:0]  site_x, n_x, side_x;
  logic [CMP_W-1:0]  right_s, down_s, right_a, left_a, down_a, up_a;
  logic [ADDR_W-1:0] addr;
  logic              we, wdata;
  logic [2:0]        up_cnt, k;
  logic              flip;
  logic [5:0]        ene_delta;
  logic [MAG_W-1:0]  mag_next;
  logic [ENE_W-1:0]  ene_next;

  // helical neighbors, all modulo N
  always_comb begin
    site_x  = CMP_W'(site);
    n_x     = CMP_W'(n);
    side_x  = CMP_W'(side_use);
    right_s = site_x + CMP_W'(1);
    right_a = (right_s >= n_x) ? right_s - n_x : right_s;
    left_a  = (site_x == '0) ? n_x - CMP_W'(1) : site_x - CMP_W'(1);
    down_s  = site_x + side_x;
    down_a  = (down_s >= n_x) ? down_s - n_x : down_s;
    up_a    = (site_x < side_x) ? site_x + n_x - side_x : site_x - side_x;
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_SITE:  addr = site_x[ADDR_W-1:0];
      ADDR_RIGHT: addr = right_a[ADDR_W-1:0];
      ADDR_LEFT:  addr = left_a[ADDR_W-1:0];
      ADDR_DOWN:  addr = down_a[ADDR_W-1:0];
      ADDR_UP:    addr = up_a[ADDR_W-1:0];
      ADDR_CLEAR: addr = clr_addr;
      default:    addr = site_x[ADDR_W-1:0];
    endcase
  end

  // k counts neighbors aligned with the site spin; d = 2k - 4
  always_comb begin
    up_cnt    = ups + {2'b00, rd_q};
    k         = spin_s ? up_cnt : 3'd4 - up_cnt;
    flip      = !err && ((k <= 3'd2) ||
                         (k == 3'd3 && rnd < thr_small) ||
                         (k == 3'd4 && rnd < thr_large));
    ene_delta = {1'b0, k, 2'b00} - 6'd8;
    mag_next  = spin_s ? mag - MAG_W'(2) : mag + MAG_W'(2);
    ene_next  = ene + {{(ENE_W-6){ene_delta[5]}}, ene_delta};
    we        = cmd.clr_en | (cmd.finish & flip);
    wdata     = cmd.clr_en | ~spin_s;
  end

  // single-port spin store
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (cmd.rd_en) rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || init) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign sts.clr_last = (COUNT_W'(clr_addr) + COUNT_W'(1)) == n;
  assign sts.err      = err;
  assign sts.out_busy = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      site <= site_index;
      rnd  <= random_fraction;
      err  <= CMP_W'(site_index) >= CMP_W'(n);
    end
    if (cmd.cap_spin) begin
      spin_s <= rd_q;
      ups    <= '0;
    end else if (cmd.acc) begin
      ups <= up_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      mag <= MAG_W'(n);
      ene <= ENE_W'(0) - ENE_W'({n, 1'b0});
    end else if (cmd.finish && flip) begin
      mag <= mag_next;
      ene <= ene_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      flipped       <= flip;
      spin_after    <= !err && (spin_s ^ flip);
      magnetisation <= flip ? mag_next : mag;
      energy        <= flip ? ene_next : ene;
      index_error   <= err;
    end
  end

endmodule

### hw/rtl/ising_metropolis_spin_update.sv
// Metropolis single-spin-flip trial on a 2-D Ising lattice with helical wrap.
// Input channel (in_valid / in_stall): one beat per trial, carrying site_index
// and a 16-bit random_fraction. Output channel (out_valid / out_stall): one
// beat per trial with flipped, spin_after, the running magnetisation and
// energy, and index_error for a site not below N = side^2.
// Registers on the APB port: lattice_side at 0x0, accept_threshold_small at
// 0x4 (used for d = 2), accept_threshold_large at 0x8 (used for d = 4).
// Trials run one at a time: one single-port spin memory handles five reads
// (site and four neighbors) and the write-back, one per cycle, though the
// write-back waits while the previous result is stalled. The result is
// registered with the write-back; an index error skips the reads.
// The result sits in an output register; while it is stalled, the next trial
// runs up to its final step and waits there for the register to free.
// Reset, and every write of lattice_side, sets all spins up and the totals to
// N and -2N, then sweeps the memory one entry per cycle; in_stall stays high
// until the sweep is done.
module ising_metropolis_spin_update import imsu_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SITE_W-1:0]       site_index,
  input  logic [RND_W-1:0]        random_fraction,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    flipped,
  output logic                    spin_after,
  output logic signed [MAG_W-1:0] magnetisation,
  output logic signed [ENE_W-1:0] energy,
  output logic                    index_error
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int COUNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);

  logic [SIDE_W-1:0]  side_use;
  logic [COUNT_W-1:0] n;
  logic [THR_W-1:0]   thr_small, thr_large;
  logic               init;
  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;

  imsu_regs #(.MAX_SIDE(MAX_SIDE)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .side_use  (side_use),
    .n         (n),
    .thr_small (thr_small),
    .thr_large (thr_large),
    .init      (init)
  );

  imsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .init     (init),
    .sts      (sts),
    .cmd      (cmd)
  );

  imsu_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .init            (init),
    .side_use        (side_use),
    .n               (n),
    .thr_small       (thr_small),
    .thr_large       (thr_large),
    .site_index      (site_index),
    .random_fraction (random_fraction),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .flipped         (flipped),
    .spin_after      (spin_after),
    .magnetisation   (magnetisation),
    .energy          (energy),
    .index_error     (index_error)
  );

endmodule

### hw/rtl/imsu_checker.sv
module imsu_checker import imsu_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    flipped,
  input logic                    spin_after,
  input logic                    index_error,
  input logic signed [MAG_W-1:0] magnetisation
);

  // clear sweep follows reset
  a_stall_after_rst: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // one trial in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while a trial is running");

  a_err_no_change: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_error) |-> (!flipped && !spin_after))
    else $error("index error beat reports a flip or an up spin");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(magnetisation)))
    else $error("stalled result changed");

endmodule

bind ising_metropolis_spin_update imsu_checker u_chk (.*);

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import imsu_pkg::*;

  typedef struct {
    logic                    flipped;
    logic                    spin_after;
    logic signed [MAG_W-1:0] mag;
    logic signed [ENE_W-1:0] ene;
    logic                    index_error;
  } trial_outcome_t;

  typedef enum {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_t;

  // Tracks the lattice, the totals and the registers; predicts one outcome per trial.
  class lattice_tracker;
    bit                    spin_up [0:MAX_SIDE_DEF*MAX_SIDE_DEF-1];
    logic [CFG_SIDE_W-1:0] side_reg;
    logic [THR_W-1:0]      thr_small;
    logic [THR_W-1:0]      thr_large;
    int                    mag_total;
    int                    ene_total;
    trial_outcome_t        pending[$];
    int                    mismatch_count;

    function int active_side();
      if (side_reg < MIN_SIDE) return MIN_SIDE;
      if (side_reg > MAX_SIDE_DEF) return MAX_SIDE_DEF;
      return int'(side_reg);
    endfunction

    function int spin_total();
      return active_side() * active_side();
    endfunction

    function void fill_lattice();
      int n;
      n = spin_total();
      foreach (spin_up[i]) spin_up[i] = 1'b1;
      mag_total = n;
      ene_total = -2 * n;
    endfunction

    function void power_on();
      side_reg = CFG_SIDE_W'(RESET_SIDE);
      thr_small = THR_W'(RESET_SMALL);
      thr_large = THR_W'(RESET_LARGE);
      mismatch_count = 0;
      fill_lattice();
    endfunction

    function void note_register(logic [PADDR_W-3:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_SIDE: begin
          side_reg = value[CFG_SIDE_W-1:0];
          fill_lattice();
        end
        REG_SMALL: thr_small = value[THR_W-1:0];
        REG_LARGE: thr_large = value[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int spin_value(int idx);
      return spin_up[idx] ? 1 : -1;
    endfunction

    function void predict_trial(logic [SITE_W-1:0] site_idx, logic [RND_W-1:0] rnd);
      trial_outcome_t o;
      int n, l, site, s, nsum, d;
      int right, left, down, up;
      bit flip;
      n = spin_total();
      l = active_side();
      site = int'(site_idx);
      flip = 1'b0;
      o.flipped = 1'b0;
      o.spin_after = 1'b0;
      o.index_error = 1'b0;
      if (site >= n) begin
        o.index_error = 1'b1;
      end else begin
        // helical wrap: all four neighbors taken mod N
        right = (site + 1) % n;
        left = (site + n - 1) % n;
        down = (site + l) % n;
        up = (site + n - l) % n;
        s = spin_value(site);
        nsum = spin_value(right) + spin_value(left) + spin_value(down) +
               spin_value(up);
        d = nsum * s;
        if (d <= 0) flip = 1'b1;
        else if (d == 2) flip = (rnd < thr_small);
        else if (d == 4) flip = (rnd < thr_large);
        if (flip) begin
          mag_total += (s > 0) ? -2 : 2;
          ene_total += 2 * d;
          s = -s;
          spin_up[site] = (s > 0);
        end
        o.flipped = flip;
        o.spin_after = (s > 0);
      end
      o.mag = MAG_W'(mag_total);
      o.ene = ENE_W'(ene_total);
      pending.push_back(o);
    endfunction

    function void check_outcome(logic f, logic sa, logic signed [MAG_W-1:0] m,
                                logic signed [ENE_W-1:0] e, logic ie);
      trial_outcome_t o;
      if (pending.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result beat with no trial pending: %s%0b %s%0b %s%0d %s%0d %s%0b",
                   $time, "flipped=", f, "spin=", sa, "mag=", m, "energy=", e, "err=", ie);
        return;
      end
      o = pending.pop_front();
      if (f !== o.flipped || sa !== o.spin_after || m !== o.mag || e !== o.ene ||
          ie !== o.index_error) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: mismatch exp flipped=%0b spin=%0b mag=%0d energy=%0d err=%0b",
                   $time, o.flipped, o.spin_after, o.mag, o.ene, o.index_error);
          $display("%0t:          got flipped=%0b spin=%0b mag=%0d energy=%0d err=%0b",
                   $time, f, sa, m, e, ie);
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SITE_W-1:0]       site_index = '0;
  logic [RND_W-1:0]        random_fraction = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    flipped;
  logic                    spin_after;
  logic signed [MAG_W-1:0] magnetisation;
  logic signed [ENE_W-1:0] energy;
  logic                    index_error;

  lattice_tracker tracker;
  int             burst_left = 0;
  stall_mode_t    stall_mode = STALL_NONE;
  int             stall_left = 0;
  int             stall_phase = 0;
  int             side_choices[13] = '{3, 4, 5, 6, 7, 8, 12, 16, 25, 40, 64, 100, 129};

  ising_metropolis_spin_update DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .site_index(site_index),
    .random_fraction(random_fraction),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .flipped(flipped),
    .spin_after(spin_after),
    .magnetisation(magnetisation),
    .energy(energy),
    .index_error(index_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, switching among several patterns
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 4));
      stall_left = int'($urandom_range(16, 200));
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
      STALL_PERIODIC: out_stall <= ((stall_phase % 7) < 3);
      default:        out_stall <= ((stall_phase % 40) < 30);
    endcase
  end

  // predict before checking: the result of a beat never leaves on its own accept edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.predict_trial(site_index, random_fraction);
      if (out_valid && !out_stall)
        tracker.check_outcome(flipped, spin_after, magnetisation, energy, index_error);
    end
  end

  task automatic send_trial(input logic [SITE_W-1:0] site, input logic [RND_W-1:0] rnd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = int'($urandom_range(1, 20));
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    site_index <= site;
    random_fraction <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_trials();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-3:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.note_register(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return THR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [RND_W-1:0] near(int thr);
    int v;
    v = thr + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return RND_W'(v);
  endfunction

  task automatic random_trials(input int count);
    int n;
    logic [SITE_W-1:0] site;
    logic [RND_W-1:0] rnd;
    repeat (count) begin
      n = tracker.spin_total();
      // mostly in-range sites; about a tenth land past the lattice unless N is 65536
      if (n > 65535 || $urandom_range(0, 9) != 0)
        site = SITE_W'($urandom_range(0, n - 1));
      else
        site = SITE_W'($urandom_range(n, 65535));
      case ($urandom_range(0, 4))
        0: rnd = RND_W'($urandom);
        1: rnd = near(int'(tracker.thr_small));
        2: rnd = near(int'(tracker.thr_large));
        3: rnd = $urandom_range(0, 1) ? '1 : '0;
        default: rnd = RND_W'($urandom_range(0, 65535));
      endcase
      send_trial(site, rnd);
    end
  endtask

  initial begin
    tracker = new();
    tracker.power_on();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset lattice: 256 x 256, corners and row seams
    send_trial(16'd0, 16'hFFFF);
    send_trial(16'd0, 16'd0);
    send_trial(16'd1, 16'd1199);
    send_trial(16'hFFFF, 16'd1200);
    send_trial(16'd0, 16'hFFFF);
    send_trial(16'hFF00, 16'd8868);
    send_trial(16'd255, 16'd8869);
    send_trial(16'd256, 16'd0);
    random_trials(60);

    // smallest lattice; aligned neighbors with a zero threshold never flip
    drain_trials();
    write_reg(REG_SIDE, 32'd2);
    write_reg(REG_SMALL, 32'hFFFF);
    write_reg(REG_LARGE, 32'd0);
    for (int i = 0; i < 4; i++) send_trial(SITE_W'(i), 16'hFFFF);
    send_trial(16'd4, 16'd0);
    send_trial(16'hFFFF, 16'd0);
    send_trial(16'd1, 16'd0);
    send_trial(16'd2, 16'd0);

    // side below range clamps to 2
    drain_trials();
    write_reg(REG_SIDE, 32'd0);
    write_reg(REG_SMALL, 32'd0);
    write_reg(REG_LARGE, 32'hFFFF);
    send_trial(16'd0, 16'hFFFE);
    send_trial(16'd1, 16'hFFFF);
    send_trial(16'd0, 16'hFFFF);
    send_trial(16'd2, 16'hFFFF);
    send_trial(16'd3, 16'd0);
    send_trial(16'd4, 16'd0);

    drain_trials();
    write_reg(REG_SIDE, 32'd1);
    random_trials(40);

    // side above range clamps to 256
    drain_trials();
    write_reg(REG_SIDE, 32'd511);
    write_reg(REG_SMALL, DATA_W'(pick_threshold()));
    write_reg(REG_LARGE, DATA_W'(pick_threshold()));
    random_trials(80);

    for (int p = 0; p < 11; p++) begin
      drain_trials();
      // some phases keep the lattice and only move the thresholds
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_SIDE, DATA_W'(side_choices[$urandom_range(0, 12)]));
      write_reg(REG_SMALL, DATA_W'(pick_threshold()));
      write_reg(REG_LARGE, DATA_W'(pick_threshold()));
      random_trials(75);
    end

    drain_trials();
    repeat (20) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
